@@ rtl/core/bgc_pkg.sv @@
// Shared types, register indexes and reset values for the button gesture classifier.
package bgc_pkg;

  // Default width of the hold and single-gap tick counters.
  localparam int unsigned TICK_BITS_DEFAULT = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned DEB_W       = 10;

  // Reset values of the configuration registers.
  localparam logic                ACTIVE_HIGH_RST  = 1'b0;
  localparam logic [DEB_W-1:0]    DEBOUNCE_RST     = 10'd50;
  localparam logic [THRESH_W-1:0] LONG_RST         = 16'd3000;
  localparam logic [THRESH_W-1:0] VERY_LONG_RST    = 16'd7000;
  localparam logic [THRESH_W-1:0] RESET_HOLD_RST   = 16'd12000;
  localparam logic [THRESH_W-1:0] DOUBLE_WIN_RST   = 16'd400;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_HIGH = 3'd0,
    REG_DEBOUNCE    = 3'd1,
    REG_LONG        = 3'd2,
    REG_VERY_LONG   = 3'd3,
    REG_RESET_HOLD  = 3'd4,
    REG_DOUBLE_WIN  = 3'd5
  } cfg_reg_t;

  // Gesture codes reported with a release.
  typedef enum logic [2:0] {
    GEST_NONE      = 3'd0,
    GEST_SINGLE    = 3'd1,
    GEST_DOUBLE    = 3'd2,
    GEST_LONG      = 3'd3,
    GEST_VERY_LONG = 3'd4,
    GEST_RESET     = 3'd5
  } gesture_t;

endpackage

@@ rtl/core/bgc_tick_if.sv @@
// Valid/ready channel that carries one raw pin sample per tick.
interface bgc_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

@@ rtl/core/bgc_result_if.sv @@
// Valid/ready channel that carries the press, release and gesture result of one tick.
interface bgc_result_if;
  logic       valid;
  logic       ready;
  logic       press_event;
  logic       release_event;
  logic [2:0] gesture;

  modport source (output valid, output press_event, output release_event, output gesture,
                  input ready);
  modport sink   (input valid, input press_event, input release_event, input gesture,
                  output ready);
endinterface

@@ rtl/core/button_gesture_classifier.sv @@
// Debounced button with press and release events and release gesture classification.
//
//   channel | dir | payload                               | transaction
//   --------+-----+---------------------------------------+---------------------------
//   tick    | in  | pin_level                             | one millisecond tick
//   result  | out | press_event, release_event, gesture   | one result per tick
//   cfg     | in  | cfg_we, cfg_index, cfg_wdata          | one register write
//
// Each tick's state update and result are computed in one pass between the state
// registers and the result register.
// A new tick is taken every cycle while the result register is empty or being drained.
// rst is synchronous and active high; it resets all but the result payload.
// A stalled result holds the tick channel off until the result is taken.
module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int unsigned TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  bgc_tick_if.sink               tick,
  bgc_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned CMP_W = (TICK_BITS > THRESH_W) ? TICK_BITS : THRESH_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
  localparam logic [DEB_W-1:0]     DEB_MAX  = {DEB_W{1'b1}};

  // Configuration registers.
  logic                active_high;
  logic [DEB_W-1:0]    debounce_ticks;
  logic [THRESH_W-1:0] long_ticks;
  logic [THRESH_W-1:0] very_long_ticks;
  logic [THRESH_W-1:0] reset_hold_ticks;
  logic [THRESH_W-1:0] double_window_ticks;

  // Tracking state.
  logic                 is_pressed, is_pressed_next;
  logic                 debounce_busy, debounce_busy_next;
  logic [DEB_W-1:0]     debounce_count, debounce_count_next;
  logic [TICK_BITS-1:0] hold_count, hold_count_next;
  logic [TICK_BITS-1:0] hold_at_release, hold_at_release_next;
  logic                 awaiting_second, awaiting_second_next;
  logic [TICK_BITS-1:0] since_single, since_single_next;

  // Result register.
  logic     out_valid;
  logic     press_q, release_q;
  gesture_t gesture_q;

  logic     tick_fire;
  logic     pressed_now;
  logic     sample;
  logic     press_next, release_next;
  gesture_t gesture_next;
  logic [TICK_BITS-1:0] hold_inc, since_inc;

  assign tick.ready = !out_valid || result.ready;
  assign tick_fire  = tick.valid && tick.ready;

  assign result.valid         = out_valid;
  assign result.press_event   = press_q;
  assign result.release_event = release_q;
  assign result.gesture       = gesture_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_high         <= ACTIVE_HIGH_RST;
      debounce_ticks      <= DEBOUNCE_RST;
      long_ticks          <= LONG_RST;
      very_long_ticks     <= VERY_LONG_RST;
      reset_hold_ticks    <= RESET_HOLD_RST;
      double_window_ticks <= DOUBLE_WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_HIGH: active_high         <= cfg_wdata[0];
        REG_DEBOUNCE:    debounce_ticks      <= cfg_wdata[DEB_W-1:0];
        REG_LONG:        long_ticks          <= cfg_wdata[THRESH_W-1:0];
        REG_VERY_LONG:   very_long_ticks     <= cfg_wdata[THRESH_W-1:0];
        REG_RESET_HOLD:  reset_hold_ticks    <= cfg_wdata[THRESH_W-1:0];
        REG_DOUBLE_WIN:  double_window_ticks <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-tick update: counters, debounce and release classification.
  always_comb begin
    pressed_now = (tick.pin_level == active_high);

    hold_inc  = (is_pressed && hold_count != TICK_MAX) ? hold_count + 1'b1 : hold_count;
    since_inc = (awaiting_second && since_single != TICK_MAX) ?
                since_single + 1'b1 : since_single;

    is_pressed_next      = is_pressed;
    debounce_busy_next   = debounce_busy;
    debounce_count_next  = debounce_count;
    hold_count_next      = hold_inc;
    hold_at_release_next = hold_at_release;
    awaiting_second_next = awaiting_second;
    since_single_next    = since_inc;
    press_next           = 1'b0;
    release_next         = 1'b0;
    gesture_next         = GEST_NONE;

    // Start a debounce on an edge, or advance a running one.
    if (!debounce_busy) begin
      if (pressed_now != is_pressed) begin
        debounce_busy_next  = 1'b1;
        debounce_count_next = '0;
        if (is_pressed) begin
          hold_at_release_next = hold_inc;
        end
      end
    end else if (debounce_count != DEB_MAX) begin
      debounce_count_next = debounce_count + 1'b1;
    end

    sample = debounce_busy_next && (debounce_count_next >= debounce_ticks);

    // The single sample decides whether the change stands.
    if (sample) begin
      debounce_busy_next = 1'b0;
      if (pressed_now != is_pressed) begin
        is_pressed_next = pressed_now;
        hold_count_next = '0;
        if (pressed_now) begin
          press_next = 1'b1;
        end else begin
          release_next = 1'b1;
          priority if (CMP_W'(hold_at_release_next) >= CMP_W'(reset_hold_ticks)) begin
            gesture_next = GEST_RESET;
          end else if (CMP_W'(hold_at_release_next) >= CMP_W'(very_long_ticks)) begin
            gesture_next = GEST_VERY_LONG;
          end else if (CMP_W'(hold_at_release_next) >= CMP_W'(long_ticks)) begin
            gesture_next = GEST_LONG;
          end else if (awaiting_second &&
                       CMP_W'(since_inc) <= CMP_W'(double_window_ticks)) begin
            gesture_next         = GEST_DOUBLE;
            awaiting_second_next = 1'b0;
            since_single_next    = '0;
          end else begin
            gesture_next         = GEST_SINGLE;
            awaiting_second_next = 1'b1;
            since_single_next    = '0;
          end
        end
      end
    end
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed      <= 1'b0;
      debounce_busy   <= 1'b0;
      debounce_count  <= '0;
      hold_count      <= '0;
      hold_at_release <= '0;
      awaiting_second <= 1'b0;
      since_single    <= '0;
    end else if (tick_fire) begin
      is_pressed      <= is_pressed_next;
      debounce_busy   <= debounce_busy_next;
      debounce_count  <= debounce_count_next;
      hold_count      <= hold_count_next;
      hold_at_release <= hold_at_release_next;
      awaiting_second <= awaiting_second_next;
      since_single    <= since_single_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      press_q   <= press_next;
      release_q <= release_next;
      gesture_q <= gesture_next;
    end
  end

`ifndef SYNTH
  // A tick never reports both a press and a release.
  a_press_release_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_q && release_q))
    else $error("press and release reported on one tick");

  // A gesture appears exactly on a release.
  a_gesture_on_release: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (release_q == (gesture_q != GEST_NONE)))
    else $error("gesture does not match release event");

  // A reported press leaves the button pressed with a fresh hold count.
  a_press_state: assert property (@(posedge clk) disable iff (rst)
    tick_fire && press_next |=> is_pressed && hold_count == '0)
    else $error("press did not update tracking state");

  // A single arms the double-click window from zero.
  a_single_arms: assert property (@(posedge clk) disable iff (rst)
    tick_fire && release_next && gesture_next == GEST_SINGLE |=>
      awaiting_second && since_single == '0)
    else $error("single did not arm the double window");

  // A reported release leaves the button released with no debounce running.
  a_release_state: assert property (@(posedge clk) disable iff (rst)
    tick_fire && release_next |=> !is_pressed && !debounce_busy)
    else $error("release did not update tracking state");
`endif

endmodule

@@ test/button_gesture_classifier_test.sv @@
// Self-checking testbench for the button gesture classifier: directed and random tests.
`timescale 1ns / 1ps

module button_gesture_classifier_test;
  import bgc_pkg::*;

  localparam int unsigned TICK_BITS        = TICK_BITS_DEFAULT;
  localparam int unsigned CLK_PERIOD_NS    = 8;
  localparam int unsigned RUN_LIMIT_CYCLES = 1_000_000;
  localparam int unsigned SPAN_CLIP        = 40;

  // Register indexes that decode to nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [DEB_W-1:0] DEB_CEILING = '1;

  typedef struct packed {
    logic     press_event;
    logic     release_event;
    gesture_t gesture;
  } tick_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bgc_tick_if   tick_ch ();
  bgc_result_if result_ch ();

  button_gesture_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies held by the predictor.
  logic                  cfg_active_high;
  logic [DEB_W-1:0]      cfg_debounce;
  logic [THRESH_W-1:0]   cfg_long;
  logic [THRESH_W-1:0]   cfg_very_long;
  logic [THRESH_W-1:0]   cfg_reset_hold;
  logic [THRESH_W-1:0]   cfg_double_win;

  // Button state held by the predictor.
  logic                  btn_pressed;
  logic                  deb_busy;
  logic [DEB_W-1:0]      deb_count;
  logic [TICK_BITS-1:0]  hold_ticks;
  logic [TICK_BITS-1:0]  hold_at_release;
  logic                  awaiting_second;
  logic [TICK_BITS-1:0]  since_single;

  tick_result_t awaited_tick_results[$];

  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned hold_off_cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned press_tally = 0;
  int unsigned release_tally = 0;
  int unsigned settings_loaded = 0;
  int unsigned mismatch_count = 0;
  int unsigned gesture_tally[6] = '{default: 0};

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  // Run limit.
  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("Run limit reached with %0d tick results outstanding.",
             awaited_tick_results.size());
    $display("** button_gesture_classifier: FAILED **");
    $finish;
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin
    int unsigned stretch;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        stretch = hold_off_cycles;
        hold_off_cycles = 0;
        result_ch.ready <= 1'b0;
        repeat (stretch) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (awaited_tick_results.size() == 0) begin
        $error("Result transaction with no tick outstanding: press %0b release %0b gesture %0d",
               result_ch.press_event, result_ch.release_event, result_ch.gesture);
        mismatch_count++;
      end else begin
        want = awaited_tick_results.pop_front();
        results_checked++;
        press_tally += 32'(want.press_event);
        release_tally += 32'(want.release_event);
        gesture_tally[want.gesture]++;
        if (result_ch.press_event !== want.press_event) begin
          $error("press_event: expected %0b, actual %0b", want.press_event,
                 result_ch.press_event);
          mismatch_count++;
        end
        if (result_ch.release_event !== want.release_event) begin
          $error("release_event: expected %0b, actual %0b", want.release_event,
                 result_ch.release_event);
          mismatch_count++;
        end
        if (result_ch.gesture !== want.gesture) begin
          $error("gesture: expected %0d, actual %0d", want.gesture, result_ch.gesture);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void reset_predictor();
    cfg_active_high = ACTIVE_HIGH_RST;
    cfg_debounce    = DEBOUNCE_RST;
    cfg_long        = LONG_RST;
    cfg_very_long   = VERY_LONG_RST;
    cfg_reset_hold  = RESET_HOLD_RST;
    cfg_double_win  = DOUBLE_WIN_RST;
    btn_pressed     = 1'b0;
    deb_busy        = 1'b0;
    deb_count       = '0;
    hold_ticks      = '0;
    hold_at_release = '0;
    awaiting_second = 1'b0;
    since_single    = '0;
  endfunction

  function automatic logic [TICK_BITS-1:0] bump_ticks(input logic [TICK_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Thresholds are tested from the longest class down, whatever their order.
  function automatic gesture_t classify_release();
    if (hold_at_release >= cfg_reset_hold) return GEST_RESET;
    if (hold_at_release >= cfg_very_long) return GEST_VERY_LONG;
    if (hold_at_release >= cfg_long) return GEST_LONG;
    if (awaiting_second && since_single <= cfg_double_win) begin
      awaiting_second = 1'b0;
      since_single    = '0;
      return GEST_DOUBLE;
    end
    awaiting_second = 1'b1;
    since_single    = '0;
    return GEST_SINGLE;
  endfunction

  // Advance the button state by one tick and return the result it reports.
  function automatic tick_result_t classify_tick(input logic pin);
    tick_result_t res;
    logic         pressed_now;
    res.press_event   = 1'b0;
    res.release_event = 1'b0;
    res.gesture       = GEST_NONE;
    pressed_now = (pin == cfg_active_high);

    if (btn_pressed) hold_ticks = bump_ticks(hold_ticks);
    if (awaiting_second) since_single = bump_ticks(since_single);

    // An edge starts the debounce; later edges are ignored until it ends.
    if (!deb_busy) begin
      if (pressed_now != btn_pressed) begin
        deb_busy  = 1'b1;
        deb_count = '0;
        if (btn_pressed) hold_at_release = hold_ticks;
      end
    end else if (deb_count < DEB_CEILING) begin
      deb_count = deb_count + 1'b1;
    end

    // Single sample at the end of the debounce.
    if (deb_busy && deb_count >= cfg_debounce) begin
      deb_busy = 1'b0;
      if (pressed_now != btn_pressed) begin
        btn_pressed = pressed_now;
        hold_ticks  = '0;
        if (pressed_now) begin
          res.press_event = 1'b1;
        end else begin
          res.release_event = 1'b1;
          res.gesture       = classify_release();
        end
      end
    end
    return res;
  endfunction

  function automatic logic pin_for(input logic pressed);
    return pressed ? cfg_active_high : ~cfg_active_high;
  endfunction

  // Send one tick transaction and record its prediction once accepted.
  task automatic send_tick(input logic pin);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.pin_level <= pin;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    awaited_tick_results.push_back(classify_tick(pin));
    ticks_sent++;
  endtask

  // Hold one level for a number of ticks, optionally with contact bounce at the start.
  task automatic send_level(input logic pressed, input int unsigned count, input bit bouncy);
    logic pin;
    for (int unsigned i = 0; i < count; i++) begin
      pin = pin_for(pressed);
      if (bouncy && i < 3 && $urandom_range(0, 1) == 1) pin = ~pin;
      send_tick(pin);
    end
  endtask

  task automatic wait_results_drained();
    tick_ch.valid <= 1'b0;
    while (awaited_tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; load_settings lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_HIGH: cfg_active_high = data[0];
      REG_DEBOUNCE:    cfg_debounce    = data[DEB_W-1:0];
      REG_LONG:        cfg_long        = data[THRESH_W-1:0];
      REG_VERY_LONG:   cfg_very_long   = data[THRESH_W-1:0];
      REG_RESET_HOLD:  cfg_reset_hold  = data[THRESH_W-1:0];
      REG_DOUBLE_WIN:  cfg_double_win  = data[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register, with junk in unused upper bits and at unused indexes.
  task automatic load_settings(input logic act, input logic [DEB_W-1:0] deb,
                               input logic [THRESH_W-1:0] long_len,
                               input logic [THRESH_W-1:0] very_long_len,
                               input logic [THRESH_W-1:0] reset_len,
                               input logic [THRESH_W-1:0] window);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_ACTIVE_HIGH, {junk[CFG_DATA_W-1:1], act});
    write_reg(REG_DEBOUNCE, {junk[CFG_DATA_W-1:DEB_W], deb});
    write_reg(REG_LONG, long_len);
    write_reg(REG_VERY_LONG, very_long_len);
    write_reg(REG_RESET_HOLD, reset_len);
    write_reg(REG_DOUBLE_WIN, window);
    write_reg(REG_UNUSED_LO, junk);
    write_reg(REG_UNUSED_HI, ~junk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Random press and release gestures sized around the current thresholds, with some noise.
  task automatic run_gesture_phase(input int unsigned n_ticks);
    int unsigned start;
    int unsigned hold_span;
    int unsigned gap_span;
    start = ticks_sent;
    hold_span = 32'(cfg_reset_hold);
    if (32'(cfg_very_long) > hold_span) hold_span = 32'(cfg_very_long);
    if (32'(cfg_long) > hold_span) hold_span = 32'(cfg_long);
    if (hold_span > SPAN_CLIP) hold_span = SPAN_CLIP;
    gap_span = (32'(cfg_double_win) > SPAN_CLIP) ? SPAN_CLIP : 32'(cfg_double_win);
    while (ticks_sent - start < n_ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        send_level(1'b1, $urandom_range(0, hold_span + 3) + 32'(cfg_debounce) + 1,
                   $urandom_range(0, 2) == 0);
        send_level(1'b0, $urandom_range(0, gap_span + 3) + 32'(cfg_debounce) + 1,
                   $urandom_range(0, 2) == 0);
      end
    end
    wait_results_drained();
  endtask

  // Registers as left by reset.
  task automatic test_reset_settings();
    run_gesture_phase(180);
  endtask

  // Every gesture with zero debounce and active-high polarity.
  task automatic test_basic_gestures();
    int unsigned taps[5] = '{1, 1, 3, 5, 7};
    load_settings(1'b1, '0, 16'd3, 16'd5, 16'd7, 16'd2);
    send_level(1'b0, 1, 1'b0);
    foreach (taps[i]) begin
      send_level(1'b1, taps[i], 1'b0);
      send_level(1'b0, 1, 1'b0);
    end
    wait_results_drained();
  endtask

  // Bounce during debounce, rejected changes both ways, and out-of-order thresholds.
  task automatic test_bounce_and_rejects();
    logic pins[18] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    load_settings(1'b0, 10'd2, 16'd2, 16'd8, 16'd4, 16'd0);
    foreach (pins[i]) send_tick(pins[i]);
    wait_results_drained();
  endtask

  // Shorten the debounce while one is running: the sample comes on the next tick.
  task automatic test_debounce_rewrite();
    load_settings(1'b0, DEB_CEILING, 16'd2, 16'd8, 16'd12, 16'd5);
    send_level(1'b1, 4, 1'b0);
    wait_results_drained();
    load_settings(1'b0, '0, 16'd2, 16'd8, 16'd12, 16'd5);
    send_level(1'b1, 2, 1'b0);
    send_level(1'b0, 1, 1'b0);
    wait_results_drained();
  endtask

  // Random gestures over several register settings and idling mixes.
  task automatic test_random_gestures();
    for (int unsigned phase = 0; phase < 6; phase++) begin
      sender_gaps = (phase % 4 == 0) || (phase % 4 == 1);
      sink_stalls = (phase % 4 == 0) || (phase % 4 == 2);
      case (phase)
        0: load_settings(1'b1, '0, '0, '0, '0, '0);
        1: load_settings(1'b0, 10'd3, '1, '1, '1, '1);
        default: load_settings(1'($urandom_range(0, 1)), DEB_W'($urandom_range(0, 4)),
                               THRESH_W'($urandom_range(1, 15)),
                               THRESH_W'($urandom_range(1, 25)),
                               THRESH_W'($urandom_range(1, 30)),
                               THRESH_W'($urandom_range(0, 25)));
      endcase
      run_gesture_phase(80);
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_result_backpressure();
    load_settings(1'b1, 10'd1, 16'd4, 16'd8, 16'd12, 16'd6);
    hold_off_cycles = 300;
    run_gesture_phase(80);
  endtask

  // Random gestures streamed back to back.
  task automatic test_streaming_gestures();
    load_settings(1'b1, 10'd1, 16'd5, 16'd10, 16'd15, 16'd6);
    run_gesture_phase(120);
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    tick_ch.valid     <= 1'b0;
    tick_ch.pin_level <= 1'b0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_basic_gestures();
    test_bounce_and_rejects();
    test_debounce_rewrite();
    test_random_gestures();
    test_result_backpressure();

    // Closing part runs without idling on either side.
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_streaming_gestures();

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d tick results over %0d register settings: %0d presses, %0d releases.",
             results_checked, settings_loaded, press_tally, release_tally);
    $display("Gestures single/double/long/very long/reset: %0d/%0d/%0d/%0d/%0d.",
             gesture_tally[GEST_SINGLE], gesture_tally[GEST_DOUBLE], gesture_tally[GEST_LONG],
             gesture_tally[GEST_VERY_LONG], gesture_tally[GEST_RESET]);
    if (mismatch_count == 0) begin
      $display("** button_gesture_classifier: PASSED **");
    end else begin
      $display("** button_gesture_classifier: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bgc_pkg.sv
rtl/core/bgc_tick_if.sv
rtl/core/bgc_result_if.sv
rtl/core/button_gesture_classifier.sv
test/button_gesture_classifier_test.sv
